// ===== sv/tbs_pkg.sv =====
package tbs_pkg;

  // Field widths of the transfer payloads.
  localparam int unsigned ModeW   = 2;
  localparam int unsigned LenW    = 10;
  localparam int unsigned WordW   = 16;
  localparam int unsigned ActionW = 3;
  localparam int unsigned CfgW    = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned TickW   = 8;
  localparam int unsigned WaitW   = 9;
  localparam int unsigned PhaseW  = 2;

  // Event kinds.
  localparam logic [ModeW-1:0] MODE_SEGMENT = 2'd0;
  localparam logic [ModeW-1:0] MODE_PACKET  = 2'd1;
  localparam logic [ModeW-1:0] MODE_TICK    = 2'd2;

  // Commands issued to the surrounding logic.
  localparam logic [ActionW-1:0] ACT_SEND    = 3'd0;
  localparam logic [ActionW-1:0] ACT_RESEND  = 3'd1;
  localparam logic [ActionW-1:0] ACT_FETCH   = 3'd2;
  localparam logic [ActionW-1:0] ACT_FINISH  = 3'd3;
  localparam logic [ActionW-1:0] ACT_TIMEOUT = 3'd4;
  localparam logic [ActionW-1:0] ACT_PEERERR = 3'd5;

  // Packet opcodes of interest.
  localparam logic [WordW-1:0] OP_ACK   = 16'd4;
  localparam logic [WordW-1:0] OP_ERROR = 16'd5;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_RETX_INTERVAL = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MAX_WAIT      = 2'd1;

  // Configuration reset values.
  localparam logic [CfgW-1:0] RETX_INTERVAL_RST = 8'd5;
  localparam logic [CfgW-1:0] MAX_WAIT_RST      = 8'd25;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [LenW-1:0]  segment_length;
    logic [WordW-1:0] packet_opcode;
    logic [WordW-1:0] packet_block;
  } in_item_t;

  typedef struct packed {
    logic [ActionW-1:0] action;
    logic [WordW-1:0]   block_number;
    logic [LenW-1:0]    data_length;
  } out_item_t;

  // Configuration write request toward the control core.
  typedef struct packed {
    logic               en;
    logic [CfgIdxW-1:0] index;
    logic [CfgW-1:0]    data;
  } cfg_wr_t;

endpackage

// ===== sv/tbs_ctrl.sv =====
module tbs_ctrl #(
  parameter int unsigned SEGMENT_SIZE = 512
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tbs_pkg::cfg_wr_t   cfg_wr_i,
  input  logic               step_en_i,
  input  tbs_pkg::in_item_t  item_i,
  output logic               res_valid_o,
  output tbs_pkg::out_item_t res_o
);
  import tbs_pkg::*;

  // Phase codes.
  localparam logic [PhaseW-1:0] PH_WAIT_SEG = 2'd0;
  localparam logic [PhaseW-1:0] PH_WAIT_ACK = 2'd1;
  localparam logic [PhaseW-1:0] PH_DONE     = 2'd2;

  // Compare width wide enough for both the length field and the segment size.
  localparam int unsigned SegW = $clog2(SEGMENT_SIZE + 1);
  localparam int unsigned CmpW = (SegW > LenW) ? SegW : LenW;
  localparam logic [CmpW-1:0] SegSize = CmpW'(SEGMENT_SIZE);

  logic [CfgW-1:0]   retx_q, retx_d;
  logic [CfgW-1:0]   max_wait_q, max_wait_d;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [WordW-1:0]  block_q, block_d;
  logic [LenW-1:0]   length_q, length_d;
  logic [TickW-1:0]  ticks_q, ticks_d;
  logic [WaitW-1:0]  wait_q, wait_d;

  logic [CmpW-1:0]   seg_ext;
  logic [CmpW-1:0]   len_ext;
  logic [LenW-1:0]   seg_sat;
  logic [TickW-1:0]  tick_inc;
  logic [WaitW-1:0]  wait_sum;

  // The user must issue configuration writes only while the block is idle; the block itself does not enforce this.
  always_comb begin
    retx_d     = retx_q;
    max_wait_d = max_wait_q;
    if (cfg_wr_i.en) begin
      if (cfg_wr_i.index == REG_RETX_INTERVAL) begin
        retx_d = cfg_wr_i.data;
      end else if (cfg_wr_i.index == REG_MAX_WAIT) begin
        max_wait_d = cfg_wr_i.data;
      end
    end
  end

  // Arithmetic shared by the event decode below.
  assign seg_ext  = CmpW'(item_i.segment_length);
  assign len_ext  = CmpW'(length_q);
  assign seg_sat  = (seg_ext > SegSize) ? LenW'(SegSize) : item_i.segment_length;
  assign tick_inc = ticks_q + TickW'(1);
  assign wait_sum = wait_q + WaitW'(retx_q);

  // One event per step: next state and at most one command.
  always_comb begin
    phase_d     = phase_q;
    block_d     = block_q;
    length_d    = length_q;
    ticks_d     = ticks_q;
    wait_d      = wait_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (step_en_i) begin
      unique case (item_i.mode)
        MODE_SEGMENT: begin
          if (phase_q == PH_WAIT_SEG) begin
            length_d           = seg_sat;
            ticks_d            = '0;
            wait_d             = '0;
            phase_d            = PH_WAIT_ACK;
            res_valid_o        = 1'b1;
            res_o.action       = ACT_SEND;
            res_o.block_number = block_q;
            res_o.data_length  = seg_sat;
          end
        end
        MODE_PACKET: begin
          if (phase_q == PH_WAIT_ACK) begin
            if (item_i.packet_opcode == OP_ERROR) begin
              phase_d            = PH_DONE;
              res_valid_o        = 1'b1;
              res_o.action       = ACT_PEERERR;
              res_o.block_number = block_q;
            end else if (item_i.packet_opcode == OP_ACK &&
                         item_i.packet_block == block_q) begin
              res_valid_o = 1'b1;
              if (len_ext == SegSize) begin
                block_d            = block_q + WordW'(1);
                phase_d            = PH_WAIT_SEG;
                ticks_d            = '0;
                wait_d             = '0;
                res_o.action       = ACT_FETCH;
                res_o.block_number = block_q + WordW'(1);
              end else begin
                phase_d            = PH_DONE;
                res_o.action       = ACT_FINISH;
                res_o.block_number = block_q;
              end
            end
          end
        end
        MODE_TICK: begin
          if (phase_q == PH_WAIT_ACK) begin
            if (tick_inc < retx_q) begin
              ticks_d = tick_inc;
            end else begin
              ticks_d            = '0;
              wait_d             = wait_sum;
              res_valid_o        = 1'b1;
              res_o.block_number = block_q;
              if (wait_sum >= WaitW'(max_wait_q)) begin
                phase_d      = PH_DONE;
                res_o.action = ACT_TIMEOUT;
              end else begin
                res_o.action      = ACT_RESEND;
                res_o.data_length = length_q;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Transfer state and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retx_q     <= RETX_INTERVAL_RST;
      max_wait_q <= MAX_WAIT_RST;
      phase_q    <= PH_WAIT_SEG;
      block_q    <= WordW'(1);
      length_q   <= '0;
      ticks_q    <= '0;
      wait_q     <= '0;
    end else begin
      retx_q     <= retx_d;
      max_wait_q <= max_wait_d;
      phase_q    <= phase_d;
      block_q    <= block_d;
      length_q   <= length_d;
      ticks_q    <= ticks_d;
      wait_q     <= wait_d;
    end
  end

`ifndef SYNTHESIS
  // Once done, no event produces a command.
  a_done_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en_i && phase_q == PH_DONE |-> !res_valid_o)
    else $error("command issued after transfer ended");

  // Aborts and completion end the transfer.
  a_end_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.action == ACT_TIMEOUT || res_o.action == ACT_FINISH ||
                    res_o.action == ACT_PEERERR) |=> phase_q == PH_DONE)
    else $error("transfer did not end after final command");

  // A fetch advances the block number by one and reports the new number.
  a_fetch_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.action == ACT_FETCH |=>
      block_q == $past(block_q) + WordW'(1) && phase_q == PH_WAIT_SEG &&
      block_q == $past(res_o.block_number))
    else $error("fetch did not advance the block number");

  // A send always moves into waiting for the acknowledgement with cleared counters.
  a_send_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.action == ACT_SEND |=>
      phase_q == PH_WAIT_ACK && ticks_q == '0 && wait_q == '0)
    else $error("send did not arm the wait counters");
`endif

endmodule

// ===== sv/tftp_block_sender.sv =====
// Path: an accepted event transfer passes through the input register, then the
// result register, where its command is offered.
// Throughput: one event per cycle while the result side takes every command;
// the event decode reads the input register combinationally and updates state on a step.
// Reset: asynchronous, active low; clears the pipeline and sets the transfer
// state and both configuration registers to their defaults.
module tftp_block_sender #(
  parameter int unsigned SEGMENT_SIZE = 512
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  tbs_pkg::in_item_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output tbs_pkg::out_item_t                  out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tbs_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [tbs_pkg::CfgW-1:0]            cfg_data_i
);
  import tbs_pkg::*;

  logic      in_valid_q;
  in_item_t  in_q;
  logic      out_valid_q;
  out_item_t out_q;
  logic      step_en;
  logic      res_valid;
  out_item_t res;
  cfg_wr_t   cfg_wr;

  // The stored event moves on whenever the result register is free or being drained.
  assign step_en     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || step_en;
  assign cfg_ready_o = 1'b1;

  assign cfg_wr.en    = cfg_valid_i;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  tbs_ctrl #(
    .SEGMENT_SIZE(SEGMENT_SIZE)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_wr_i   (cfg_wr),
    .step_en_i  (step_en),
    .item_i     (in_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  // Result register: loaded on each step, cleared once its transfer completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_en) begin
      out_valid_q <= res_valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
